@@ rtl/pmq_pkg.sv @@
// Package for the pose to position/quaternion block.
// Holds request/result structs, fixed-point constants and the square-root/divide state enum.
// No dependencies.
package pmq_pkg;

    localparam int QONE = 16384;
    localparam int VEC_W = 19;     // signed width of one unnormalized vector component
    localparam int SS_W = 38;      // width of the sum of squares
    localparam int RAD_W = 64;     // radicand width: sum of squares shifted by 26
    localparam int LEN_W = 32;     // width of the vector length
    localparam int DIV_W = 47;     // dividend width: magnitude shifted by 28, plus rounding
    localparam int QDEPTH = 2;     // entries in the queue between front and back

    localparam logic [1:0] REG_NEG_X = 2'd0;
    localparam logic [1:0] REG_NEG_Z = 2'd1;
    localparam logic [1:0] REG_SWAP = 2'd2;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } request_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z_neg;
        logic signed [15:0] quat_w_neg;
    } result_t;

    // Classified request travelling from front to back.
    typedef struct packed {
        logic signed [VEC_W-1:0] vw;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] vz;
        logic                    ok;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [31:0]      pos_z;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

@@ rtl/pmq_front.sv @@
// Front part: takes a request, applies the position adjustments and
// forms the unnormalized quaternion vector. Depends on pmq_pkg.
module pmq_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  pmq_pkg::request_t req,
    input  logic              neg_x,
    input  logic              neg_z,
    input  logic              swap_xz,
    output logic              valid,
    output pmq_pkg::work_t    work
);
    import pmq_pkg::*;

    logic   valid_reg;
    work_t  work_reg;
    work_t  work_next;

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        logic signed [32:0] r;
        r = -{v[31], v};
        if (r > 33'sd2147483647)
            return 32'sh7fffffff;
        return r[31:0];
    endfunction

    always_comb
    begin
        logic signed [VEC_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic signed [VEC_W-1:0] tr, one;
        logic signed [31:0] px, pz;
        r00 = VEC_W'(req.rot_00); r01 = VEC_W'(req.rot_01); r02 = VEC_W'(req.rot_02);
        r10 = VEC_W'(req.rot_10); r11 = VEC_W'(req.rot_11); r12 = VEC_W'(req.rot_12);
        r20 = VEC_W'(req.rot_20); r21 = VEC_W'(req.rot_21); r22 = VEC_W'(req.rot_22);
        one = VEC_W'(QONE);
        tr = r00 + r11 + r22;
        work_next.ok = 1'b1;
        if (tr > 0)
        begin
            work_next.vw = one + tr;
            work_next.vx = r21 - r12;
            work_next.vy = r02 - r20;
            work_next.vz = r10 - r01;
        end
        else if (r00 > r11 && r00 > r22)
        begin
            work_next.vw = r21 - r12;
            work_next.vx = one + r00 - r11 - r22;
            work_next.vy = r01 + r10;
            work_next.vz = r02 + r20;
            work_next.ok = work_next.vx > 0;
        end
        else if (r11 > r22)
        begin
            work_next.vw = r02 - r20;
            work_next.vx = r01 + r10;
            work_next.vy = one + r11 - r00 - r22;
            work_next.vz = r12 + r21;
            work_next.ok = work_next.vy > 0;
        end
        else
        begin
            work_next.vw = r10 - r01;
            work_next.vx = r02 + r20;
            work_next.vy = r12 + r21;
            work_next.vz = one + r22 - r00 - r11;
            work_next.ok = work_next.vz > 0;
        end
        px = neg_x ? neg_sat(req.trans_x) : req.trans_x;
        pz = neg_z ? neg_sat(req.trans_z) : req.trans_z;
        work_next.pos_x = swap_xz ? pz : px;
        work_next.pos_z = swap_xz ? px : pz;
        work_next.pos_y = req.trans_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            work_reg <= work_next;
    end

    assign valid = valid_reg;
    assign work = work_reg;
endmodule

@@ rtl/pmq_queue.sv @@
// Short queue between the front and back parts.
// Depends on pmq_pkg.
module pmq_queue
#(
    parameter int DEPTH = pmq_pkg::QDEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmq_pkg::work_t push_data,
    input  logic           pop,
    output logic           not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output pmq_pkg::work_t head
);
    import pmq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    work_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= inc(wr_reg);
            if (pop)
                rd_reg <= inc(rd_reg);
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    assign head = mem_reg[rd_reg];
    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CW'(DEPTH)) |-> !push || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count mismatch");
`endif
endmodule

@@ rtl/pmq_back.sv @@
// Back part: sum of squares, bit-serial square root and restoring
// divisions that normalize the vector. Depends on pmq_pkg.
module pmq_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  pmq_pkg::work_t    work,
    output logic              pop,
    output logic              done,
    output pmq_pkg::result_t  result
);
    import pmq_pkg::*;

    back_state_t        state_reg, state_next;
    work_t              w_reg;
    logic [SS_W-1:0]    ss_reg;
    logic [RAD_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   root_reg;
    logic [5:0]         step_reg;
    logic [1:0]         comp_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [15:0]        q_reg [4];
    result_t            res_reg;
    logic               done_reg;

    // working signals
    logic [VEC_W-1:0]   mag [4];
    logic [2*VEC_W-1:0] sq [4];
    logic [RAD_W-1:0]   rad;
    logic [RAD_W+1:0]   trial;
    logic [LEN_W+1:0]   root_trial;
    logic [DIV_W:0]     num_trial;
    logic [DIV_W-1:0]   den;
    logic [DIV_W-1:0]   qfin;
    logic [15:0]        qsat;
    logic signed [VEC_W-1:0] comp_v;

    always_comb
    begin
        logic signed [VEC_W-1:0] v [4];
        v[0] = w_reg.vw; v[1] = w_reg.vx; v[2] = w_reg.vy; v[3] = w_reg.vz;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
            sq[i] = mag[i] * mag[i];
        end
        comp_v = v[comp_reg];
    end

    // One root bit per step: the radicand is ss * 2^26, bits fed two at a time.
    assign rad = {ss_reg, 26'd0};
    always_comb
    begin
        logic [1:0] pair;
        pair = rad[RAD_W-1-2*step_reg -: 2];
        trial = {rem_reg, pair};
        root_trial = {root_reg, 2'b01};
    end

    // Quotient of (2*mag*2^27 + len) / (2*len), one bit per step.
    assign den = DIV_W'({root_reg, 1'b0});
    always_comb
    begin
        logic [DIV_W-1:0] dividend;
        dividend = ({{(DIV_W-VEC_W){1'b0}}, mag[comp_reg]} << 28)
                   + DIV_W'(root_reg);
        num_trial = {num_reg, dividend[DIV_W-1-step_reg]};
        qfin = {quo_reg[DIV_W-2:0], (num_trial >= {1'b0, den})};
        qsat = (qfin > DIV_W'(QONE)) ? 16'(QONE) : qfin[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (avail)
                begin
                    pop = 1'b1;
                    state_next = ST_SQUARE;
                end
            ST_SQUARE:
                state_next = (w_reg.ok) ? ST_SQRT : ST_DONE;
            ST_SQRT:
                if (step_reg == 6'(RAD_W/2 - 1))
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == 6'(DIV_W - 1) && comp_reg == 2'd3)
                    state_next = ST_DONE;
            ST_DONE:
                if (avail)
                begin
                    pop = 1'b1;
                    state_next = ST_SQUARE;
                end
                else
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            w_reg <= work;
        case (state_reg)
            ST_SQUARE:
            begin
                ss_reg <= SS_W'(sq[0]) + SS_W'(sq[1]) + SS_W'(sq[2]) + SS_W'(sq[3]);
                rem_reg <= '0;
                root_reg <= '0;
                step_reg <= '0;
                comp_reg <= '0;
                for (int i = 0; i < 4; i++)
                    q_reg[i] <= '0;
            end
            ST_SQRT:
            begin
                if (trial >= {root_trial, {(RAD_W-LEN_W){1'b0}}} >> (RAD_W-LEN_W))
                begin
                    rem_reg <= RAD_W'(trial - RAD_W'(root_trial));
                    root_reg <= {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= RAD_W'(trial);
                    root_reg <= {root_reg[LEN_W-2:0], 1'b0};
                end
                if (step_reg == 6'(RAD_W/2 - 1))
                begin
                    step_reg <= '0;
                    num_reg <= '0;
                    quo_reg <= '0;
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
            ST_DIV:
            begin
                if (step_reg == 6'(DIV_W - 1))
                begin
                    q_reg[comp_reg] <= comp_v[VEC_W-1] ? 16'(-qsat) : qsat;
                    step_reg <= '0;
                    num_reg <= '0;
                    quo_reg <= '0;
                    comp_reg <= comp_reg + 1'b1;
                end
                else
                begin
                    if (num_trial >= {1'b0, den})
                        num_reg <= DIV_W'(num_trial - {1'b0, den});
                    else
                        num_reg <= DIV_W'(num_trial);
                    quo_reg <= qfin;
                    step_reg <= step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                res_reg.pos_x <= w_reg.pos_x;
                res_reg.pos_y <= w_reg.pos_y;
                res_reg.pos_z <= w_reg.pos_z;
                res_reg.quat_x <= q_reg[1];
                res_reg.quat_y <= q_reg[2];
                res_reg.quat_z_neg <= 16'(-q_reg[3]);
                res_reg.quat_w_neg <= 16'(-q_reg[0]);
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE || state_reg == ST_DONE) && avail)
        else $error("pop outside idle or done");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> done_reg)
        else $error("result strobe missing");
    a_degenerate_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE && !w_reg.ok) |=> state_reg == ST_DONE)
        else $error("degenerate item not skipped");
`endif
endmodule

@@ rtl/pose_matrix_to_position_quaternion.sv @@
// Pose to position and unit quaternion (Q2.14) with configurable position
// negation and x/z swap. A request passes the front register, the queue, the pop,
// the square step, the bit-serial root, four restoring divisions and the output
// register before the done strobe; a degenerate request skips root and divisions.
// The back part works on one request at a time and sets the sustained rate; busy rises
// when queue plus front register hold the queue depth. Reset (rst_n, async, active
// low) clears config, queue and control state; the receiver cannot stall.
module pose_matrix_to_position_quaternion
#(
    parameter int QUEUE_DEPTH = pmq_pkg::QDEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pmq_pkg::request_t request,
    output logic              done,
    output pmq_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [0:0]        cfg_data
);
    import pmq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic neg_x_reg, neg_z_reg, swap_reg;
    logic take;
    logic f_valid;
    work_t f_work;
    logic q_not_empty, q_pop;
    logic [CW-1:0] q_count;
    work_t q_head;

    // Hold configuration; index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_x_reg <= 1'b0;
            neg_z_reg <= 1'b0;
            swap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEG_X: neg_x_reg <= cfg_data[0];
                REG_NEG_Z: neg_z_reg <= cfg_data[0];
                REG_SWAP:  swap_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Reserve a queue slot for the request still in the front register.
    assign busy = (CW'(q_count) + CW'(f_valid)) >= CW'(QUEUE_DEPTH);
    assign take = start && !busy;

    pmq_front u_front
    (
        .clk(clk), .rst_n(rst_n), .take(take), .req(request),
        .neg_x(neg_x_reg), .neg_z(neg_z_reg), .swap_xz(swap_reg),
        .valid(f_valid), .work(f_work)
    );

    pmq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_work),
        .pop(q_pop), .not_empty(q_not_empty), .count(q_count), .head(q_head)
    );

    pmq_back u_back
    (
        .clk(clk), .rst_n(rst_n), .avail(q_not_empty), .work(q_head),
        .pop(q_pop), .done(done), .result(result)
    );

`ifndef SYNTHESIS
    a_take_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !busy)
        else $error("request taken while busy");
    a_front_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> f_valid)
        else $error("front lost a request");
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> q_count < CW'(QUEUE_DEPTH) || q_pop)
        else $error("queue has no room for front");
`endif
endmodule

@@ tb/pose_result_checker.sv @@
// Result checker for pose_matrix_to_position_quaternion: watches the request, config and result
// channels, predicts each result and compares it field by field.
// Depends on pmq_pkg for the payload structs and register indexes.
`timescale 1ns / 1ps

module pose_result_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pmq_pkg::request_t request,
    input  logic              done,
    input  pmq_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [0:0]        cfg_data,
    output int                errors,
    output int                pending
);
    import pmq_pkg::*;

    bit       neg_x;
    bit       neg_z;
    bit       swap_xz;
    result_t  expected_poses[$];

    function automatic longint scale_to_unit(longint comp, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        begin
            mag = longint'(comp < 0 ? -comp : comp) << 27;
            q = (2 * mag + len) / (2 * len);
            if (q > QONE)
                q = QONE;
            return comp < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint negate_sat(longint p);
        longint r;
        begin
            r = -p;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            return r;
        end
    endfunction

    // Position adjust plus trace / largest-diagonal quaternion, normalized.
    function automatic result_t predict_pose(request_t r, bit nx, bit nz, bit sw);
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint tr;
        longint v[4];
        longint q[4];
        longint px, py, pz, t;
        bit ok;
        longint unsigned ss, rem, root, probe;
        result_t o;
        begin
            m00 = r.rot_00; m01 = r.rot_01; m02 = r.rot_02;
            m10 = r.rot_10; m11 = r.rot_11; m12 = r.rot_12;
            m20 = r.rot_20; m21 = r.rot_21; m22 = r.rot_22;
            ok = 1'b1;
            q = '{0, 0, 0, 0};
            tr = m00 + m11 + m22;
            if (tr > 0) begin
                v = '{QONE + tr, m21 - m12, m02 - m20, m10 - m01};
            end else if (m00 > m11 && m00 > m22) begin
                v = '{m21 - m12, QONE + m00 - m11 - m22, m01 + m10, m02 + m20};
                ok = v[1] > 0;
            end else if (m11 > m22) begin
                v = '{m02 - m20, m01 + m10, QONE + m11 - m00 - m22, m12 + m21};
                ok = v[2] > 0;
            end else begin
                v = '{m10 - m01, m02 + m20, m12 + m21, QONE + m22 - m00 - m11};
                ok = v[3] > 0;
            end
            if (ok) begin
                ss = 0;
                foreach (v[i])
                    ss += longint'(v[i] * v[i]);
                // bit-pair integer square root of ss * 2^26
                rem = ss << 26;
                root = 0;
                probe = 64'd1 << 62;
                while (probe > rem)
                    probe >>= 2;
                while (probe != 0) begin
                    if (rem >= root + probe) begin
                        rem -= root + probe;
                        root = (root >> 1) + probe;
                    end else begin
                        root >>= 1;
                    end
                    probe >>= 2;
                end
                if (root != 0)
                    foreach (v[i])
                        q[i] = scale_to_unit(v[i], root);
            end
            px = r.trans_x;
            py = r.trans_y;
            pz = r.trans_z;
            if (nx)
                px = negate_sat(px);
            if (nz)
                pz = negate_sat(pz);
            if (sw) begin
                t = px;
                px = pz;
                pz = t;
            end
            o.pos_x = px[31:0];
            o.pos_y = py[31:0];
            o.pos_z = pz[31:0];
            o.quat_x = q[1][15:0];
            o.quat_y = q[2][15:0];
            o.quat_z_neg = -q[3][15:0];
            o.quat_w_neg = -q[0][15:0];
            return o;
        end
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        begin
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t e;
        if (!rst_n) begin
            neg_x <= 1'b0;
            neg_z <= 1'b0;
            swap_xz <= 1'b0;
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_NEG_X: neg_x <= cfg_data[0];
                    REG_NEG_Z: neg_z <= cfg_data[0];
                    REG_SWAP:  swap_xz <= cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_poses.insert(expected_poses.size(),
                                      predict_pose(request, neg_x, neg_z, swap_xz));
            if (done) begin
                if (expected_poses.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = expected_poses.pop_front();
                    check_field("pos_x", e.pos_x, result.pos_x);
                    check_field("pos_y", e.pos_y, result.pos_y);
                    check_field("pos_z", e.pos_z, result.pos_z);
                    check_field("quat_x", e.quat_x, result.quat_x);
                    check_field("quat_y", e.quat_y, result.quat_y);
                    check_field("quat_z_neg", e.quat_z_neg, result.quat_z_neg);
                    check_field("quat_w_neg", e.quat_w_neg, result.quat_w_neg);
                end
            end
        end
        pending <= expected_poses.size();
    end

endmodule

@@ tb/pose_matrix_to_position_quaternion_tb.sv @@
// Testbench top for pose_matrix_to_position_quaternion: makes requests and config writes,
// gives the verdict. Depends on pmq_pkg, the block and pose_result_checker.
`timescale 1ns / 1ps

module pose_matrix_to_position_quaternion_tb;
    import pmq_pkg::*;

    // index past the register list; the block must ignore writes to it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_REQUESTS = 225;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    request_t   request;
    logic       done;
    result_t    result;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [0:0] cfg_data;
    int         errors;
    int         pending;

    pose_matrix_to_position_quaternion u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pose_result_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Present one request and hold it until accepted; drop start afterwards unless
    // the next request of the burst follows right away.
    task automatic send_request(request_t r, bit keep_start);
        begin
            start <= 1'b1;
            request <= r;
            do @(posedge clk); while (busy);
            if (!keep_start)
                start <= 1'b0;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, bit val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Advance until every outstanding result has arrived and the back end has settled.
    task automatic wait_drained();
        begin
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (10) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_translation();
        int sel;
        begin
            sel = $urandom_range(0, 19);
            case (sel)
                0: return 32'h8000_0000;   // most negative, saturates when negated
                1: return 32'h7fff_ffff;
                2: return 32'h0;
                default: return $urandom;
            endcase
        end
    endfunction

    function automatic logic [15:0] to_q14(real val);
        int n;
        begin
            n = $rtoi(val * 16384.0 + (val < 0 ? -0.5 : 0.5));
            n += int'($urandom_range(0, 4)) - 2;   // small sensor noise
            return n[15:0];
        end
    endfunction

    // Mostly proper rotations from a random quaternion; the rest raw noise
    // and matrices built on ties and extremes of the diagonal.
    function automatic request_t random_pose();
        request_t r;
        real w, x, y, z, n;
        logic [15:0] edge_vals[4];
        int kind;
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                w = real'(int'($urandom_range(0, 2000)) - 1000);
                x = real'(int'($urandom_range(0, 2000)) - 1000);
                y = real'(int'($urandom_range(0, 2000)) - 1000);
                z = real'(int'($urandom_range(0, 2000)) - 1000);
                n = $sqrt(w * w + x * x + y * y + z * z);
                if (n == 0.0) begin
                    w = 1.0;
                    n = 1.0;
                end
                w /= n; x /= n; y /= n; z /= n;
                r.rot_00 = to_q14(1.0 - 2.0 * (y * y + z * z));
                r.rot_01 = to_q14(2.0 * (x * y - z * w));
                r.rot_02 = to_q14(2.0 * (x * z + y * w));
                r.rot_10 = to_q14(2.0 * (x * y + z * w));
                r.rot_11 = to_q14(1.0 - 2.0 * (x * x + z * z));
                r.rot_12 = to_q14(2.0 * (y * z - x * w));
                r.rot_20 = to_q14(2.0 * (x * z - y * w));
                r.rot_21 = to_q14(2.0 * (y * z + x * w));
                r.rot_22 = to_q14(1.0 - 2.0 * (x * x + y * y));
            end else if (kind < 85) begin
                r.rot_00 = $urandom; r.rot_01 = $urandom; r.rot_02 = $urandom;
                r.rot_10 = $urandom; r.rot_11 = $urandom; r.rot_12 = $urandom;
                r.rot_20 = $urandom; r.rot_21 = $urandom; r.rot_22 = $urandom;
            end else begin
                edge_vals = '{16'h8000, 16'h7fff, 16'hc000, 16'h4000};
                r.rot_00 = edge_vals[$urandom_range(0, 3)];
                r.rot_11 = ($urandom_range(0, 1) != 0) ? r.rot_00
                                                       : edge_vals[$urandom_range(0, 3)];
                r.rot_22 = ($urandom_range(0, 1) != 0) ? r.rot_11
                                                       : edge_vals[$urandom_range(0, 3)];
                r.rot_01 = edge_vals[$urandom_range(0, 3)];
                r.rot_02 = $urandom;
                r.rot_10 = edge_vals[$urandom_range(0, 3)];
                r.rot_12 = $urandom;
                r.rot_20 = edge_vals[$urandom_range(0, 3)];
                r.rot_21 = $urandom;
            end
            r.trans_x = pick_translation();
            r.trans_y = pick_translation();
            r.trans_z = pick_translation();
            return r;
        end
    endfunction

    // Directed poses: identity, half turns about each axis (one per diagonal
    // branch), zero matrix, all-max, all-min and diagonal ties.
    function automatic request_t directed_pose(int idx);
        request_t r;
        logic [15:0] d0, d1, d2;
        begin
            r = '0;
            case (idx)
                0: begin d0 = 16'h4000; d1 = 16'h4000; d2 = 16'h4000; end
                1: begin d0 = 16'h4000; d1 = 16'hc000; d2 = 16'hc000; end
                2: begin d0 = 16'hc000; d1 = 16'h4000; d2 = 16'hc000; end
                3: begin d0 = 16'hc000; d1 = 16'hc000; d2 = 16'h4000; end
                4: begin d0 = 16'h0;    d1 = 16'h0;    d2 = 16'h0;    end
                5: begin d0 = 16'h7fff; d1 = 16'h7fff; d2 = 16'h7fff; end
                6: begin d0 = 16'h8000; d1 = 16'h8000; d2 = 16'h8000; end
                7: begin d0 = 16'hc000; d1 = 16'hc000; d2 = 16'h8000; end
                default: begin d0 = 16'h8000; d1 = 16'hc000; d2 = 16'hc000; end
            endcase
            r.rot_00 = d0;
            r.rot_11 = d1;
            r.rot_22 = d2;
            if (idx == 5) begin
                r.rot_01 = 16'h7fff; r.rot_02 = 16'h7fff; r.rot_10 = 16'h7fff;
                r.rot_12 = 16'h7fff; r.rot_20 = 16'h7fff; r.rot_21 = 16'h7fff;
                r.trans_x = 32'h7fff_ffff; r.trans_y = 32'h7fff_ffff; r.trans_z = 32'h7fff_ffff;
            end else if (idx == 6) begin
                r.rot_01 = 16'h8000; r.rot_02 = 16'h8000; r.rot_10 = 16'h8000;
                r.rot_12 = 16'h8000; r.rot_20 = 16'h8000; r.rot_21 = 16'h8000;
                r.trans_x = 32'h8000_0000; r.trans_y = 32'h8000_0000; r.trans_z = 32'h8000_0000;
            end else begin
                r.trans_x = 32'h0001_8000 * idx;
                r.trans_y = -32'sd65536 * idx;
                r.trans_z = 32'h8000_0000 + idx;
            end
            return r;
        end
    endfunction

    initial begin
        int settings[8];
        int burst_left;
        bit last_of_burst;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = REG_NEG_X;
        cfg_data = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray write past the list must leave every register alone.
        write_reg(REG_UNUSED, 1'b1);

        for (int i = 0; i < 9; i++)
            send_request(directed_pose(i), i < 4);
        start <= 1'b0;

        // Walk through the register settings, extremes first.
        settings = '{7, 0, 1, 2, 4, 3, 5, 6};
        foreach (settings[p]) begin
            wait_drained();
            write_reg(REG_NEG_X, settings[p][0]);
            write_reg(REG_NEG_Z, settings[p][1]);
            write_reg(REG_SWAP, settings[p][2]);
            burst_left = 0;
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 8);
                burst_left--;
                last_of_burst = (burst_left == 0) || (k == PHASE_REQUESTS - 1);
                send_request(random_pose(), !last_of_burst);
                // gap between bursts, sometimes none at all
                if (last_of_burst && $urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 300)) @(posedge clk);
            end
        end

        wait_drained();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard limit on the whole run.
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
